>>> rtl/utf8sd_pkg.sv
// ============================================================================
// UTF-8 strict decoder package
// Shared constants, lead byte classes and the run descriptor that the front
// end hands to the back end.
// ============================================================================
package utf8sd_pkg;

  // Widths of the stream fields.
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CpW    = 21;
  localparam int unsigned CountW = 3;

  // Byte classification and code point limits.
  localparam logic [7:0]     ContMask   = 8'hC0;
  localparam logic [7:0]     ContTag    = 8'h80;
  localparam logic [CpW-1:0] MinTwo     = 21'h00080;
  localparam logic [CpW-1:0] MinThree   = 21'h00800;
  localparam logic [CpW-1:0] SurrLow    = 21'h0D800;
  localparam logic [CpW-1:0] SurrHigh   = 21'h0DFFF;
  localparam logic [CpW-1:0] MinFour    = 21'h10000;
  localparam logic [CpW-1:0] MaxScalar  = 21'h10FFFF;

  // Class of a byte seen in lead position.
  typedef enum logic [2:0] {
    LEAD_ASCII = 3'd0,
    LEAD_TWO   = 3'd1,
    LEAD_THREE = 3'd2,
    LEAD_FOUR  = 3'd3,
    LEAD_BAD   = 3'd4
  } lead_cls_e;

  // One request's worth of results: count results in total, all but the
  // last of them invalid single bytes, the last one described by the rest.
  typedef struct packed {
    logic [CountW-1:0] count;
    logic [CpW-1:0]    code_point;
    logic              invalid;
    logic [CountW-1:0] byte_count;
  } run_t;

  function automatic lead_cls_e classify(input logic [ByteW-1:0] b);
    lead_cls_e cls;
    if (b[7] == 1'b0) begin
      cls = LEAD_ASCII;
    end else if (b[7:5] == 3'b110) begin
      cls = LEAD_TWO;
    end else if (b[7:4] == 4'b1110) begin
      cls = LEAD_THREE;
    end else if (b[7:3] == 5'b11110) begin
      cls = LEAD_FOUR;
    end else begin
      cls = LEAD_BAD;
    end
    return cls;
  endfunction

endpackage

>>> rtl/utf8sd_stream_if.sv
// ============================================================================
// UTF-8 strict decoder stream interfaces
// Byte input channel and result output channel, valid/ready handshake.
// ============================================================================
interface utf8sd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_input;

  modport source (output valid, output data_byte, output end_of_input, input ready);
  modport sink   (input valid, input data_byte, input end_of_input, output ready);
endinterface

interface utf8sd_out_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic        invalid;
  logic [2:0]  byte_count;
  logic        last_of_run;

  modport source (output valid, output code_point, output invalid, output byte_count,
                  output last_of_run, input ready);
  modport sink   (input valid, input code_point, input invalid, input byte_count,
                  input last_of_run, output ready);
endinterface

>>> rtl/utf8sd_front.sv
// ============================================================================
// UTF-8 strict decoder front end
// Accepts one byte per cycle unless the run queue is full, tracks the pending
// sequence and turns each byte with results into a back-end run descriptor.
// ============================================================================
module utf8sd_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  utf8sd_in_if.sink             in_i,
  input  logic                  full_i,
  output logic                  push_o,
  output utf8sd_pkg::run_t      run_o
);

  logic [7:0] lead_q, lead_d;
  logic [1:0] need_q, need_d;
  logic [1:0] held_q, held_d;
  logic [7:0] tail_q [2];
  logic       tail_wr;
  logic       accept;

  utf8sd_pkg::lead_cls_e cls;
  logic [1:0]            cls_need;
  logic                  tl_emit;
  logic [2:0]            pre_n;
  logic [20:0]           cp_full;
  logic                  cp_ok;
  logic [7:0]            b;
  logic                  eoi;

  assign b      = in_i.data_byte;
  assign eoi    = in_i.end_of_input;
  assign accept = in_i.valid && in_i.ready;
  assign in_i.ready = !full_i;

  always_comb begin
    cls = utf8sd_pkg::classify(b);
    case (cls)
      utf8sd_pkg::LEAD_TWO:   cls_need = 2'd1;
      utf8sd_pkg::LEAD_THREE: cls_need = 2'd2;
      utf8sd_pkg::LEAD_FOUR:  cls_need = 2'd3;
      default:                cls_need = 2'd0;
    endcase
    tl_emit = (cls == utf8sd_pkg::LEAD_ASCII) || (cls == utf8sd_pkg::LEAD_BAD) || eoi;
  end

  // Code point of a sequence that completes with this byte.
  always_comb begin
    case (need_q)
      2'd1:    cp_full = {10'd0, lead_q[4:0], b[5:0]};
      2'd2:    cp_full = {5'd0, lead_q[3:0], tail_q[0][5:0], b[5:0]};
      2'd3:    cp_full = {lead_q[2:0], tail_q[0][5:0], tail_q[1][5:0], b[5:0]};
      default: cp_full = '0;
    endcase
    case (need_q)
      2'd1:    cp_ok = cp_full >= utf8sd_pkg::MinTwo;
      2'd2:    cp_ok = (cp_full >= utf8sd_pkg::MinThree) &&
                       !((cp_full >= utf8sd_pkg::SurrLow) && (cp_full <= utf8sd_pkg::SurrHigh));
      2'd3:    cp_ok = (cp_full >= utf8sd_pkg::MinFour) && (cp_full <= utf8sd_pkg::MaxScalar);
      default: cp_ok = 1'b0;
    endcase
  end

  always_comb begin
    lead_d  = lead_q;
    need_d  = need_q;
    held_d  = held_q;
    tail_wr = 1'b0;
    pre_n   = '0;
    run_o   = '{count: '0, code_point: '0, invalid: 1'b1, byte_count: 3'd1};

    if ((need_q == 2'd0) || ((b & utf8sd_pkg::ContMask) != utf8sd_pkg::ContTag)) begin
      // Nothing pending, or a pending sequence broken by a non-continuation:
      // the pending bytes are rejected and this byte is examined as a lead.
      pre_n = (need_q == 2'd0) ? 3'd0 : ({1'b0, held_q} + 3'd1);
      if (tl_emit) begin
        run_o.count = pre_n + 3'd1;
        if (cls == utf8sd_pkg::LEAD_ASCII) begin
          run_o.code_point = {13'd0, b};
          run_o.invalid    = 1'b0;
        end
        need_d = 2'd0;
        held_d = 2'd0;
      end else begin
        run_o.count = pre_n;
        lead_d      = b;
        need_d      = cls_need;
        held_d      = 2'd0;
      end
    end else if (({1'b0, held_q} + 3'd1) >= {1'b0, need_q}) begin
      if (cp_ok) begin
        run_o.count      = 3'd1;
        run_o.code_point = cp_full;
        run_o.invalid    = 1'b0;
        run_o.byte_count = {1'b0, need_q} + 3'd1;
      end else begin
        run_o.count = {1'b0, need_q} + 3'd1;
      end
      need_d = 2'd0;
      held_d = 2'd0;
    end else begin
      tail_wr = 1'b1;
      held_d  = held_q + 2'd1;
      if (eoi) begin
        run_o.count = {1'b0, held_q} + 3'd2;
        need_d      = 2'd0;
        held_d      = 2'd0;
      end
    end
  end

  assign push_o = accept && (run_o.count != 3'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q <= '0;
      need_q <= '0;
      held_q <= '0;
    end else if (accept) begin
      lead_q <= lead_d;
      need_q <= need_d;
      held_q <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && tail_wr) begin
      tail_q[held_q[0]] <= b;
    end
  end

  // A pending sequence never holds as many tails as it needs.
  a_held_below_need: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (need_q != 2'd0) |-> (held_q < need_q))
    else $error("held tail count reached the needed count");

  // Nothing is held once nothing is pending.
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (need_q == 2'd0) |-> (held_q == 2'd0))
    else $error("tails held with no pending lead");

endmodule

>>> rtl/utf8sd_queue.sv
// ============================================================================
// UTF-8 strict decoder run queue
// Two-entry FIFO of run descriptors between front end and back end.
// ============================================================================
module utf8sd_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  utf8sd_pkg::run_t push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output utf8sd_pkg::run_t pop_data_o,
  output logic             empty_o
);

  utf8sd_pkg::run_t mem_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       fill_q;

  assign full_o     = fill_q == 2'd2;
  assign empty_o    = fill_q == 2'd0;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        fill_q <= fill_q + 2'd1;
      end else if (pop_i && !push_i) begin
        fill_q <= fill_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into a full run queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from an empty run queue");

endmodule

>>> rtl/utf8sd_back.sv
// ============================================================================
// UTF-8 strict decoder back end
// Expands each run descriptor into its results, one per cycle while the
// receiver is ready, from an output register.
// ============================================================================
module utf8sd_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             empty_i,
  input  utf8sd_pkg::run_t run_i,
  output logic             pop_o,
  utf8sd_out_if.source     out_o
);

  logic             act_q;
  logic [2:0]       left_q;
  utf8sd_pkg::run_t run_q;
  logic             is_last;
  logic             advance;

  assign is_last = left_q == 3'd1;
  assign advance = !act_q || (out_o.ready && is_last);
  assign pop_o   = advance && !empty_i;

  assign out_o.valid       = act_q;
  assign out_o.last_of_run = is_last;
  assign out_o.invalid     = is_last ? run_q.invalid : 1'b1;
  assign out_o.code_point  = is_last ? run_q.code_point : '0;
  assign out_o.byte_count  = is_last ? run_q.byte_count : 3'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q  <= 1'b0;
      left_q <= '0;
    end else if (advance) begin
      act_q  <= !empty_i;
      left_q <= run_i.count;
    end else if (out_o.ready) begin
      left_q <= left_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      run_q <= run_i;
    end
  end

  a_left_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    act_q |-> ((left_q != 3'd0) && (left_q <= 3'd4)))
    else $error("result counter out of range while active");

endmodule

>>> rtl/utf8_strict_decoder.sv
// ============================================================================
// UTF-8 strict decoder
// Strict byte-stream UTF-8 decoder with separate accept and emit stages.
// ============================================================================
// The decoder takes one byte per request on in_i, with end_of_input marking
// the last byte of a stream, and delivers on out_o one result per complete
// valid sequence (code point and its length in bytes) or one invalid result
// per rejected byte, restarting one byte after a failed lead. The last result
// that a byte causes carries last_of_run; bytes that only extend a pending
// sequence cause no result. Input is taken at one byte per cycle as long as
// each byte causes at most one result and the receiver is ready: the back end
// drives one result per cycle from its output register while the receiver is
// ready, and a byte that causes k results holds the output until all k are
// taken. A two-entry queue of run descriptors sits between the front end and
// the back end, so input is refused only when that queue is full, and a
// result passes through a queue entry and the back-end output register.
module utf8_strict_decoder (
  input  logic          clk_i,
  input  logic          rst_ni,
  utf8sd_in_if.sink     in_i,
  utf8sd_out_if.source  out_o
);

  // Front end to queue.
  logic             push;
  logic             full;
  utf8sd_pkg::run_t push_run;

  // Queue to back end.
  logic             pop;
  logic             empty;
  utf8sd_pkg::run_t pop_run;

  // The front end holds the pending lead and tails and classifies each byte.
  utf8sd_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .run_o  (push_run)
  );

  // Short queue that lets either side stall without the other.
  utf8sd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_run),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_run),
    .empty_o     (empty)
  );

  // The back end expands each descriptor into individual results.
  utf8sd_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .run_i   (pop_run),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

>>> sim/testbench.sv
// ============================================================================
// UTF-8 strict decoder testbench
// Feeds byte requests through the input channel with bursty timing, predicts
// every decoded character or rejected byte, and checks the result channel in
// order against those predictions while the receiver stalls on its own
// pattern.
// ============================================================================
module testbench;

  localparam int unsigned ByteW  = utf8sd_pkg::ByteW;
  localparam int unsigned CpW    = utf8sd_pkg::CpW;
  localparam int unsigned CountW = utf8sd_pkg::CountW;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             end_of_input;
  } byte_req_t;

  typedef struct packed {
    logic [CpW-1:0]    code_point;
    logic              invalid;
    logic [CountW-1:0] byte_count;
    logic              last_of_run;
  } char_result_t;

  logic clk_i;
  logic rst_ni;

  utf8sd_in_if  in_if ();
  utf8sd_out_if out_if ();

  utf8_strict_decoder i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Stimulus and scoreboard bookkeeping.
  byte_req_t    byte_queue[$];
  char_result_t due_chars[$];
  byte_req_t    next_req;
  char_result_t got_char;
  char_result_t want_char;
  int unsigned  total_reqs;
  int unsigned  sent_cnt;
  int unsigned  taken_cnt;
  int unsigned  mismatch_cnt;
  int unsigned  burst_left;
  int unsigned  gap_left;
  int unsigned  rx_cycle;

  // Decoder state as the predictor sees it.
  logic [ByteW-1:0] seq_lead;
  logic [ByteW-1:0] seq_tail[3];
  int unsigned      seq_held;
  int unsigned      seq_need;

  // Results caused by the request under prediction.
  char_result_t step_out[4];
  int unsigned  step_n;

  always #5 clk_i = ~clk_i;

  function automatic void emit_char(input logic [CpW-1:0] cp, input logic bad,
                                    input logic [CountW-1:0] cnt);
    step_out[step_n] = '{code_point: cp, invalid: bad, byte_count: cnt, last_of_run: 1'b0};
    step_n++;
  endfunction

  // The pending lead and every held tail are rejected one by one.
  function automatic void reject_pending();
    emit_char('0, 1'b1, 3'd1);
    for (int i = 0; i < seq_held; i++) begin
      emit_char('0, 1'b1, 3'd1);
    end
    seq_held = 0;
    seq_need = 0;
  endfunction

  function automatic void start_lead(input logic [ByteW-1:0] b, input logic eoi);
    utf8sd_pkg::lead_cls_e cls;
    if (b inside {[8'h00:8'h7F]}) begin
      cls = utf8sd_pkg::LEAD_ASCII;
    end else if (b inside {[8'hC0:8'hDF]}) begin
      cls = utf8sd_pkg::LEAD_TWO;
    end else if (b inside {[8'hE0:8'hEF]}) begin
      cls = utf8sd_pkg::LEAD_THREE;
    end else if (b inside {[8'hF0:8'hF7]}) begin
      cls = utf8sd_pkg::LEAD_FOUR;
    end else begin
      cls = utf8sd_pkg::LEAD_BAD;
    end
    if (cls == utf8sd_pkg::LEAD_ASCII) begin
      emit_char(CpW'(b), 1'b0, 3'd1);
    end else if (cls == utf8sd_pkg::LEAD_BAD || eoi) begin
      // A multi-byte lead on the last byte of a stream is already truncated.
      emit_char('0, 1'b1, 3'd1);
    end else begin
      seq_lead = b;
      seq_held = 0;
      seq_need = (cls == utf8sd_pkg::LEAD_TWO) ? 1 : (cls == utf8sd_pkg::LEAD_THREE) ? 2 : 3;
    end
  endfunction

  function automatic void decode_byte(input logic [ByteW-1:0] b, input logic eoi);
    int unsigned      cp;
    bit               ok;
    logic [ByteW-1:0] lead_bits;
    step_n = 0;
    if (seq_need == 0) begin
      start_lead(b, eoi);
    end else if (b[7:6] != 2'b10) begin
      // Broken sequence: the new byte gets a second look as a lead.
      reject_pending();
      start_lead(b, eoi);
    end else if (seq_held + 1 >= seq_need) begin
      lead_bits = (seq_need == 1) ? (seq_lead & 8'h1F) :
                  (seq_need == 2) ? (seq_lead & 8'h0F) : (seq_lead & 8'h07);
      cp = {24'd0, lead_bits};
      for (int i = 0; i < seq_held; i++) begin
        cp = (cp << 6) | seq_tail[i][5:0];
      end
      cp = (cp << 6) | b[5:0];
      if (seq_need == 1) begin
        ok = cp >= utf8sd_pkg::MinTwo;
      end else if (seq_need == 2) begin
        ok = cp >= utf8sd_pkg::MinThree &&
             !(cp >= utf8sd_pkg::SurrLow && cp <= utf8sd_pkg::SurrHigh);
      end else begin
        ok = cp >= utf8sd_pkg::MinFour && cp <= utf8sd_pkg::MaxScalar;
      end
      if (ok) begin
        emit_char(CpW'(cp), 1'b0, CountW'(seq_need + 1));
        seq_held = 0;
        seq_need = 0;
      end else begin
        // Overlong, surrogate or out of range: every byte is rejected.
        reject_pending();
        emit_char('0, 1'b1, 3'd1);
      end
    end else begin
      seq_tail[seq_held] = b;
      seq_held++;
      if (eoi) begin
        reject_pending();
      end
    end
    if (step_n > 0) begin
      step_out[step_n-1].last_of_run = 1'b1;
    end
    for (int i = 0; i < step_n; i++) begin
      due_chars.push_back(step_out[i]);
    end
  endfunction

  // Encodes a value in the given length without range checks, so that
  // overlong, surrogate and too-large forms come out of it as well.
  function automatic logic [31:0] pack_utf8(input logic [CpW-1:0] cp, input int len);
    case (len)
      1: return {1'b0, cp[6:0], 24'h0};
      2: return {3'b110, cp[10:6], 2'b10, cp[5:0], 16'h0};
      3: return {4'b1110, cp[15:12], 2'b10, cp[11:6], 2'b10, cp[5:0], 8'h0};
      default: begin
        return {5'b11110, cp[20:18], 2'b10, cp[17:12], 2'b10, cp[11:6], 2'b10, cp[5:0]};
      end
    endcase
  endfunction

  task automatic queue_byte(input logic [ByteW-1:0] b, input logic eoi);
    byte_queue.push_back('{data_byte: b, end_of_input: eoi});
  endtask

  // Queues the first len bytes of a packed sequence, eoi on the last one.
  task automatic queue_packed(input logic [31:0] w, input int len, input logic eoi);
    for (int i = 0; i < len; i++) begin
      queue_byte(w[31-8*i -: 8], eoi && (i == len - 1));
    end
  endtask

  function automatic logic [CpW-1:0] random_scalar(input int len);
    logic [CpW-1:0] cp;
    case (len)
      1: cp = CpW'($urandom_range(0, 'h7F));
      2: cp = CpW'($urandom_range('h80, 'h7FF));
      3: begin
        cp = CpW'($urandom_range('h800, 'hFFFF));
        if (cp >= utf8sd_pkg::SurrLow && cp <= utf8sd_pkg::SurrHigh) begin
          cp = cp - 21'h01000;
        end
      end
      default: cp = CpW'($urandom_range('h10000, 'h10FFFF));
    endcase
    return cp;
  endfunction

  initial begin
    logic [ByteW-1:0] b;
    logic [CpW-1:0]   cp;
    logic             eoi;
    int               kind;
    int               len;
    int               cut;

    clk_i              = 1'b0;
    rst_ni             = 1'b0;
    in_if.valid        = 1'b0;
    in_if.data_byte    = '0;
    in_if.end_of_input = 1'b0;
    out_if.ready       = 1'b0;
    seq_lead           = '0;
    seq_held           = 0;
    seq_need           = 0;
    sent_cnt           = 0;
    taken_cnt          = 0;
    mismatch_cnt       = 0;
    burst_left         = 1;
    gap_left           = 0;
    rx_cycle           = 0;

    // Directed part: field extremes and each failure kind.
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h7F, 1'b1);
    queue_packed(32'hDFBF0000, 2, 1'b0);  // largest two-byte value
    queue_packed(32'hC0800000, 2, 1'b0);  // overlong two-byte form
    queue_packed(32'hE0A08000, 3, 1'b0);  // smallest three-byte value
    queue_packed(32'hEDA08000, 3, 1'b0);  // surrogate
    queue_packed(32'hF48FBFBF, 4, 1'b0);  // largest scalar value
    queue_packed(32'hF4908080, 4, 1'b0);  // above the scalar range
    queue_byte(8'h80, 1'b0);              // stray continuation
    queue_byte(8'hFF, 1'b0);              // bad lead
    queue_byte(8'hE2, 1'b1);              // lead on the last byte of a stream
    queue_packed(32'hE2820000, 2, 1'b1);  // truncated by end of input
    queue_packed(32'hC3410000, 2, 1'b0);  // bad continuation, then ASCII

    // Random part: mostly well-formed sequences, the rest noise and breakage.
    total_reqs = 110;
    while (byte_queue.size() < total_reqs) begin
      kind = $urandom_range(0, 19);
      eoi  = ($urandom_range(0, 7) == 0);
      if (kind < 11) begin
        len = $urandom_range(1, 4);
        queue_packed(pack_utf8(random_scalar(len), len), len, eoi);
      end else if (kind < 13) begin
        queue_byte(ByteW'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else if (kind < 16) begin
        len = $urandom_range(2, 4);
        case ($urandom_range(0, 2))
          0: cp = CpW'($urandom_range(0, (len == 2) ? 'h7F : (len == 3) ? 'h7FF : 'hFFFF));
          1: begin
            len = 3;
            cp  = CpW'($urandom_range(utf8sd_pkg::SurrLow, utf8sd_pkg::SurrHigh));
          end
          default: begin
            len = 4;
            cp  = CpW'($urandom_range('h110000, 'h1FFFFF));
          end
        endcase
        queue_packed(pack_utf8(cp, len), len, eoi);
      end else if (kind < 18) begin
        len = $urandom_range(2, 4);
        cut = $urandom_range(1, len - 1);
        queue_packed(pack_utf8(random_scalar(len), len), cut, 1'b1);
      end else begin
        len = $urandom_range(2, 4);
        cut = $urandom_range(1, len - 1);
        queue_packed(pack_utf8(random_scalar(len), len), cut, 1'b0);
        do begin
          b = ByteW'($urandom_range(0, 255));
        end while (b[7:6] == 2'b10);
        queue_byte(b, eoi);
      end
    end
    total_reqs = byte_queue.size();

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (taken_cnt != total_reqs || due_chars.size() != 0) begin
      @(posedge clk_i);
    end
    // Keep running so that any stray result still shows up.
    repeat (20) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

  // Byte sender: bursts of random length separated by random gaps.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || taken_cnt == sent_cnt) begin
      if (gap_left > 0 || byte_queue.size() == 0) begin
        if (gap_left > 0) begin
          gap_left--;
        end
        in_if.valid <= 1'b0;
      end else begin
        next_req = byte_queue.pop_front();
        in_if.data_byte    <= next_req.data_byte;
        in_if.end_of_input <= next_req.end_of_input;
        in_if.valid        <= 1'b1;
        sent_cnt++;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
        end
      end
    end
  end

  // Result receiver: always ready, lightly stalled or heavily stalled,
  // taking the three patterns in turn.
  always @(negedge clk_i) begin
    rx_cycle++;
    case ((rx_cycle / 97) % 3)
      0:       out_if.ready <= 1'b1;
      1:       out_if.ready <= ($urandom_range(0, 1) == 0);
      default: out_if.ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Predicts on each accepted request and checks each accepted result.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        decode_byte(in_if.data_byte, in_if.end_of_input);
        taken_cnt++;
      end
      if (out_if.valid && out_if.ready) begin
        got_char = '{code_point: out_if.code_point, invalid: out_if.invalid,
                     byte_count: out_if.byte_count, last_of_run: out_if.last_of_run};
        if (due_chars.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("unexpected result: cp=%h invalid=%b count=%0d last=%b",
                     got_char.code_point, got_char.invalid, got_char.byte_count,
                     got_char.last_of_run);
          end
        end else begin
          want_char = due_chars.pop_front();
          if (got_char !== want_char) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
              $display("mismatch: expected cp=%h invalid=%b count=%0d last=%b",
                       want_char.code_point, want_char.invalid, want_char.byte_count,
                       want_char.last_of_run);
              $display("          actual   cp=%h invalid=%b count=%0d last=%b",
                       got_char.code_point, got_char.invalid, got_char.byte_count,
                       got_char.last_of_run);
            end
          end
        end
      end
    end
  end

endmodule
